FILE: design/mrpt_pkg.sv
`timescale 1ns / 1ps
package mrpt_pkg;
	localparam int NumWidthDefault = 63;
	localparam int NumBases = 12;
	localparam int BaseIdxWidth = 4;
	localparam int BaseWidth = 6;

	// Fixed witness bases, tried in this order.
	function automatic logic [BaseWidth-1:0] base_at(input logic [BaseIdxWidth-1:0] idx);
		logic [BaseWidth-1:0] b;
		begin
			case (idx)
				4'd0: b = 6'd2;
				4'd1: b = 6'd3;
				4'd2: b = 6'd5;
				4'd3: b = 6'd7;
				4'd4: b = 6'd11;
				4'd5: b = 6'd13;
				4'd6: b = 6'd17;
				4'd7: b = 6'd19;
				4'd8: b = 6'd23;
				4'd9: b = 6'd29;
				4'd10: b = 6'd31;
				4'd11: b = 6'd37;
				default: b = 6'd37;
			endcase
			return b;
		end
	endfunction
endpackage

FILE: design/mrpt_mulmod.sv
`timescale 1ns / 1ps
module mrpt_mulmod #(
	parameter int W = 63
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [W-1:0] x,
	input logic [W-1:0] y,
	input logic [W-1:0] m,
	output logic done,
	output logic [W-1:0] prod
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] acc_q;
	logic [W-1:0] x_q;
	logic [W-1:0] y_q;
	logic [W-1:0] m_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [W:0] dbl;
	logic [W-1:0] dbl_r;
	logic [W:0] add;
	logic [W-1:0] add_r;

	// One bit of y per cycle: double, then conditionally add x, both mod m.
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : dbl[W-1:0];
		add = {1'b0, dbl_r} + {1'b0, x_q};
		add_r = (add >= {1'b0, m_q}) ? W'(add - {1'b0, m_q}) : add[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q <= x;
			y_q <= y;
			m_q <= m;
		end else if (run_q) begin
			acc_q <= y_q[W-1] ? add_r : dbl_r;
			y_q <= {y_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

FILE: design/miller_rabin_primality_test.sv
`timescale 1ns / 1ps
// Deterministic Miller-Rabin test of one unsigned word per start pulse. busy is
// high from the accepted start until the single done strobe, which carries
// is_prime for exactly one cycle; the receiver cannot stall it, so it must take
// the word in that cycle. All modular products go through one shift-and-add
// multiplier, so one word takes up to about 12 bases x 2*NUM_WIDTH products,
// and far fewer for numbers below 2 or with few bases.
module miller_rabin_primality_test #(
	parameter int NUM_WIDTH = mrpt_pkg::NumWidthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NUM_WIDTH-1:0] number,
	output logic busy,
	output logic done,
	output logic is_prime
);
	import mrpt_pkg::*;

	localparam int W = NUM_WIDTH;
	localparam int SW = $clog2(W + 1);

	localparam logic [3:0] StIdle = 4'd0;
	localparam logic [3:0] StSplit = 4'd1;
	localparam logic [3:0] StBase = 4'd2;
	localparam logic [3:0] StPowBit = 4'd3;
	localparam logic [3:0] StPowMul = 4'd4;
	localparam logic [3:0] StPowSq = 4'd5;
	localparam logic [3:0] StCheck = 4'd6;
	localparam logic [3:0] StSqr = 4'd7;
	localparam logic [3:0] StSqrChk = 4'd8;
	localparam logic [3:0] StDone = 4'd9;

	logic [3:0] state_q;
	logic [W-1:0] n_q;
	logic [W-1:0] d_q;
	logic [W-1:0] e_q;
	logic [SW-1:0] s_q;
	logic [SW-1:0] r_q;
	logic [W-1:0] res_q;
	logic [W-1:0] sq_q;
	logic [BaseIdxWidth-1:0] k_q;
	logic prime_q;
	logic done_q;
	logic mm_start;
	logic [W-1:0] mm_x;
	logic [W-1:0] mm_y;
	logic mm_done;
	logic [W-1:0] mm_prod;
	logic [W-1:0] nm1;
	logic [W-1:0] base_w;

	assign nm1 = n_q - 1'b1;
	assign base_w = W'(base_at(k_q));

	// Shared modular multiplier.
	mrpt_mulmod #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .x(mm_x), .y(mm_y),
		.m(n_q), .done(mm_done), .prod(mm_prod)
	);

	// Operand selection for each product the sequencer issues.
	always_comb begin
		mm_start = 1'b0;
		mm_x = sq_q;
		mm_y = sq_q;
		case (state_q)
			StPowBit: begin
				if (e_q != '0) begin
					mm_start = 1'b1;
					if (e_q[0]) begin
						mm_x = res_q;
					end
				end
			end
			StPowMul: begin
				if (mm_done) begin
					mm_start = 1'b1;
				end
			end
			StCheck: begin
				mm_x = res_q;
				mm_y = res_q;
				mm_start = !(res_q == W'(1) || res_q == nm1) && (r_q < s_q);
			end
			StSqrChk: begin
				mm_x = res_q;
				mm_y = res_q;
				mm_start = (res_q != nm1) && (r_q < s_q);
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			done_q <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (start) begin
						state_q <= StSplit;
					end
				end
				StSplit: begin
					if (n_q <= W'(1)) begin
						prime_q <= 1'b0;
						state_q <= StDone;
					end else if (!d_q[0]) begin
						state_q <= StSplit;
					end else begin
						prime_q <= 1'b1;
						state_q <= StBase;
					end
				end
				StBase: begin
					if (k_q == BaseIdxWidth'(NumBases) || base_w >= n_q) begin
						state_q <= StDone;
					end else begin
						state_q <= StPowBit;
					end
				end
				StPowBit: begin
					if (e_q == '0) begin
						state_q <= StCheck;
					end else if (e_q[0]) begin
						state_q <= StPowMul;
					end else begin
						state_q <= StPowSq;
					end
				end
				StPowMul: begin
					if (mm_done) begin
						state_q <= StPowSq;
					end
				end
				StPowSq: begin
					if (mm_done) begin
						state_q <= StPowBit;
					end
				end
				StCheck: begin
					if (res_q == W'(1) || res_q == nm1) begin
						state_q <= StBase;
					end else if (r_q < s_q) begin
						state_q <= StSqr;
					end else begin
						prime_q <= 1'b0;
						state_q <= StDone;
					end
				end
				StSqr: begin
					if (mm_done) begin
						state_q <= StSqrChk;
					end
				end
				StSqrChk: begin
					if (res_q == nm1) begin
						state_q <= StBase;
					end else if (r_q < s_q) begin
						state_q <= StSqr;
					end else begin
						prime_q <= 1'b0;
						state_q <= StDone;
					end
				end
				StDone: begin
					done_q <= 1'b1;
					state_q <= StIdle;
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				if (start) begin
					n_q <= number;
					d_q <= number - 1'b1;
					s_q <= '0;
					k_q <= '0;
				end
			end
			StSplit: begin
				if (!d_q[0] && n_q > W'(1)) begin
					d_q <= d_q >> 1;
					s_q <= s_q + 1'b1;
				end
			end
			StBase: begin
				e_q <= d_q;
				res_q <= W'(1);
				sq_q <= base_w;
				r_q <= SW'(1);
			end
			StPowMul: begin
				if (mm_done) begin
					res_q <= mm_prod;
				end
			end
			StPowSq: begin
				if (mm_done) begin
					sq_q <= mm_prod;
					e_q <= e_q >> 1;
				end
			end
			StCheck: begin
				if (res_q == W'(1) || res_q == nm1) begin
					k_q <= k_q + 1'b1;
				end
			end
			StSqr: begin
				if (mm_done) begin
					res_q <= mm_prod;
					r_q <= r_q + 1'b1;
				end
			end
			StSqrChk: begin
				if (res_q == nm1) begin
					k_q <= k_q + 1'b1;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign busy = (state_q != StIdle);
	assign done = done_q;
	assign is_prime = prime_q;
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
	localparam int Width = mrpt_pkg::NumWidthDefault;
	localparam int RandomWords = 76;
	localparam int IdleLimit = 600000;
	localparam int DrainCycles = 100;

	typedef struct {
		logic [Width-1:0] value;
		bit has_answer;
		bit answer;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [Width-1:0] number = '0;
	logic busy;
	logic done;
	logic is_prime;

	bit expected_prime_q[$];
	int mismatches = 0;
	int idle_cycles = 0;

	miller_rabin_primality_test #(.NUM_WIDTH(Width)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.number(number),
		.busy(busy),
		.done(done),
		.is_prime(is_prime)
	);

	always #2 clk = ~clk;

	// Exact (x * y) mod m by shift-and-add; operands are below m < 2^63.
	function automatic logic [63:0] mod_product(input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd0;
		for (int bit_idx = Width - 1; bit_idx >= 0; bit_idx--) begin
			acc = acc + acc;
			if (acc >= m) acc = acc - m;
			if (y[bit_idx]) begin
				acc = acc + x;
				if (acc >= m) acc = acc - m;
			end
		end
		return acc;
	endfunction

	function automatic logic [63:0] mod_power(input logic [63:0] b, input logic [63:0] e,
			input logic [63:0] m);
		logic [63:0] res;
		logic [63:0] sq;
		res = 64'd1 % m;
		sq = b % m;
		while (e != 0) begin
			if (e[0]) res = mod_product(res, sq, m);
			sq = mod_product(sq, sq, m);
			e = e >> 1;
		end
		return res;
	endfunction

	// Deterministic Miller-Rabin over the twelve fixed bases.
	function automatic bit prime_verdict(input logic [Width-1:0] value);
		logic [63:0] n;
		logic [63:0] odd_part;
		logic [63:0] x;
		logic [63:0] a;
		int twos;
		bit passed;
		n = {1'b0, value};
		if (n <= 1) return 1'b0;
		odd_part = n - 1;
		twos = 0;
		while (!odd_part[0]) begin
			odd_part = odd_part >> 1;
			twos++;
		end
		for (int k = 0; k < mrpt_pkg::NumBases; k++) begin
			a = 64'(mrpt_pkg::base_at(k[mrpt_pkg::BaseIdxWidth-1:0]));
			if (a >= n) break;
			x = mod_power(a, odd_part, n);
			passed = (x == 1) || (x == n - 1);
			for (int r = 1; r < twos && !passed; r++) begin
				x = mod_product(x, x, n);
				if (x == n - 1) passed = 1'b1;
			end
			if (!passed) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Offer one word and hold start until the block takes it. Start stays high
	// until the next gap, since a busy block ignores it.
	task automatic send_word(input logic [Width-1:0] value, input bit has_answer,
			input bit answer);
		bit verdict;
		verdict = has_answer ? answer : prime_verdict(value);
		number <= value;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_prime_q = {expected_prime_q, verdict};
	endtask

	// Sender gaps come in bursts: a few back-to-back words, then a pause.
	int burst_left = 0;
	task automatic sender_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 6);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Result checking and the watchdog on lack of progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (done) begin
				if (expected_prime_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual is_prime=%0b",
						$time, is_prime);
					mismatches++;
				end else begin
					if (is_prime !== expected_prime_q[0]) begin
						$display("%0t: is_prime expected %0b actual %0b", $time,
							expected_prime_q[0], is_prime);
						mismatches++;
					end
					void'(expected_prime_q.pop_front());
				end
			end
			if (idle_cycles >= IdleLimit) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	stim_row_t directed[] = '{
		'{63'd0, 1'b1, 1'b0},
		'{63'd1, 1'b1, 1'b0},
		'{63'd2, 1'b1, 1'b1},
		'{63'd3, 1'b1, 1'b1},
		'{63'd4, 1'b1, 1'b0},
		'{63'd5, 1'b0, 1'b0},
		'{63'd7, 1'b0, 1'b0},
		'{63'd9, 1'b0, 1'b0},
		'{63'd13, 1'b0, 1'b0},
		'{63'd25, 1'b0, 1'b0},
		'{63'd31, 1'b0, 1'b0},
		'{63'd37, 1'b0, 1'b0},
		'{63'd38, 1'b0, 1'b0},
		'{63'd41, 1'b0, 1'b0},
		'{63'd561, 1'b0, 1'b0},
		'{63'd2047, 1'b0, 1'b0},
		'{63'd3215031751, 1'b0, 1'b0},
		'{63'd3825123056546413051, 1'b0, 1'b0},
		'{63'd2305843009213693951, 1'b0, 1'b0},
		'{63'd9223372036854775783, 1'b0, 1'b0},
		'{63'h7fff_ffff_ffff_ffff, 1'b1, 1'b0},
		'{63'h7fff_ffff_ffff_fffe, 1'b1, 1'b0},
		'{63'h5555_5555_5555_5555, 1'b0, 1'b0},
		'{63'h2aaa_aaaa_aaaa_aaab, 1'b0, 1'b0}
	};

	initial begin
		logic [Width-1:0] value;
		int bits;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_word(directed[i].value, directed[i].has_answer, directed[i].answer);
			sender_gap();
		end

		// Mostly narrow words keep the run short; a few use the full width.
		for (int i = 0; i < RandomWords; i++) begin
			bits = ($urandom_range(0, 15) == 0) ? Width : $urandom_range(2, 14);
			value = Width'({$urandom, $urandom}) & ((Width'(1) << bits) - Width'(1));
			if (bits == Width) value[Width-1] = 1'b1;
			if ($urandom_range(0, 1)) value[0] = 1'b1;
			send_word(value, 1'b0, 1'b0);
			sender_gap();
		end
		start <= 1'b0;

		while (expected_prime_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
